@@ hw/rtl/gsrs_pkg.sv @@
// Grouped sparse row sum: shared types and constants.
// Used by the accumulator bank, the emit sequencer and the top level; depends on nothing.
package gsrs_pkg;

   localparam int CMD_W   = 2;
   localparam int CELL_W  = 16;
   localparam int GIDX_W  = 6;
   localparam int VALUE_W = 32;
   localparam int ACC_W   = 48;
   localparam int COUNT_W = 7;
   // wide enough to compare any cell index with the largest map depth
   localparam int CELL_CMP_W = 25;

   localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EOR = 2'd2;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EMIT
   } gsrs_state_type;

   // control from the emit sequencer to the top level and the accumulator bank
   typedef struct packed {
      logic busy;    // end of row in progress
      logic rd_en;   // read accumulator at the walk address
      logic clear;   // drop all accumulators after the final read
      logic vld;     // a sum word is on the bank read data this cycle
      logic last;    // that word is the final one of the row
   } gsrs_emit_ctrl_type;

endpackage

@@ hw/rtl/gsrs_cell_map.sv @@
// Cell-to-group map: synchronous RAM, one write and one read port.
// Depends on nothing; read data is registered.
module gsrs_cell_map #(
   parameter int DEPTH   = 65536,
   parameter int CELL_AW = 16,
   parameter int GRP_AW  = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [CELL_AW-1:0] wr_addr,
   input  logic [GRP_AW-1:0]  wr_grp,
   input  logic               rd_en,
   input  logic [CELL_AW-1:0] rd_addr,
   output logic [GRP_AW-1:0]  rd_grp
);

   logic [GRP_AW-1:0] mem_ff [DEPTH];
   logic [GRP_AW-1:0] rd_grp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_grp;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_grp_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_grp = rd_grp_ff;

endmodule

@@ hw/rtl/gsrs_acc_bank.sv @@
// Group accumulator bank: 48-bit accumulator RAM with per-group valid bits,
// saturating read-modify-write add with one-deep write forwarding.
// Depends on gsrs_pkg.
module gsrs_acc_bank #(
   parameter int MAX_GROUPS = 64,
   parameter int GRP_AW     = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                add_vld,
   input  logic [GRP_AW-1:0]                   add_grp,
   input  logic signed [gsrs_pkg::VALUE_W-1:0] add_value,
   input  logic                                emit_rd,
   input  logic [GRP_AW-1:0]                   emit_addr,
   input  logic                                clear_all,
   output logic signed [gsrs_pkg::ACC_W-1:0]   rd_sum,
   output logic                                pending
);
   import gsrs_pkg::*;

   logic signed [ACC_W-1:0] acc_mem_ff [MAX_GROUPS];
   logic [MAX_GROUPS-1:0]   valid_ff;
   logic [MAX_GROUPS-1:0]   valid_in;

   logic signed [ACC_W-1:0]   acc_rd_ff;
   logic                      rd_valid_ff;
   logic                      s2_vld_ff;
   logic [GRP_AW-1:0]         s2_grp_ff;
   logic signed [VALUE_W-1:0] s2_value_ff;

   // last write, kept for the read that raced it
   logic                    wr_vld_ff;
   logic [GRP_AW-1:0]       wr_grp_ff;
   logic signed [ACC_W-1:0] wr_data_ff;

   logic                    rd_en;
   logic [GRP_AW-1:0]       rd_addr;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W:0]   sum_wide;
   logic signed [ACC_W-1:0] sum_sat;

   assign rd_en   = add_vld | emit_rd;
   assign rd_addr = add_vld ? add_grp : emit_addr;

   always_comb begin
      if (wr_vld_ff && (wr_grp_ff == s2_grp_ff)) begin
         base = wr_data_ff;
      end else if (rd_valid_ff) begin
         base = acc_rd_ff;
      end else begin
         base = '0;
      end
      sum_wide = {base[ACC_W-1], base}
               + {{(ACC_W+1-VALUE_W){s2_value_ff[VALUE_W-1]}}, s2_value_ff};
      // clamp when the two top bits disagree
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (s2_vld_ff) begin
         valid_in[s2_grp_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         acc_mem_ff[s2_grp_ff] <= sum_sat;
      end
      if (rd_en) begin
         acc_rd_ff <= acc_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      s2_grp_ff   <= add_grp;
      s2_value_ff <= add_value;
      wr_grp_ff   <= s2_grp_ff;
      wr_data_ff  <= sum_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         s2_vld_ff   <= 1'b0;
         wr_vld_ff   <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         s2_vld_ff <= add_vld;
         wr_vld_ff <= s2_vld_ff;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_sum  = rd_valid_ff ? acc_rd_ff : '0;
   assign pending = s2_vld_ff;

endmodule

@@ hw/rtl/gsrs_emit_seq.sv @@
// End-of-row sequencer: waits for the add pipeline to drain, then walks
// groups 0 .. group_count-1 through the accumulator read port. Depends on gsrs_pkg.
module gsrs_emit_seq #(
   parameter int GRP_AW = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start_emit,
   input  logic                              pipe_busy,
   input  logic [gsrs_pkg::COUNT_W-1:0]      group_count,
   output gsrs_pkg::gsrs_emit_ctrl_type      ctrl,
   output logic [GRP_AW-1:0]                 rd_addr,
   output logic [GRP_AW-1:0]                 slot
);
   import gsrs_pkg::*;

   gsrs_state_type    state_ff, state_in;
   logic [GRP_AW-1:0] idx_ff, idx_in;
   logic              em_vld_ff, em_last_ff;
   logic [GRP_AW-1:0] em_slot_ff;
   logic              at_last;

   assign at_last = (COUNT_W'(idx_ff) == (group_count - COUNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_emit) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (at_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.busy  = 1'b0;
      ctrl.rd_en = 1'b0;
      ctrl.clear = 1'b0;
      ctrl.vld   = em_vld_ff;
      ctrl.last  = em_last_ff;
      idx_in     = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
         end
         ST_DRAIN: begin
            ctrl.busy = 1'b1;
         end
         ST_EMIT: begin
            ctrl.busy  = 1'b1;
            ctrl.rd_en = 1'b1;
            ctrl.clear = at_last;
            idx_in     = idx_ff + GRP_AW'(1);
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         em_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         em_vld_ff <= ctrl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      em_slot_ff <= idx_ff;
      em_last_ff <= at_last;
   end

   assign rd_addr   = idx_ff;
   assign slot      = em_slot_ff;

endmodule

@@ hw/rtl/grouped_sparse_row_sum_top.sv @@
// Grouped sparse row sum, top level: command decode, group count register,
// result word mux. Depends on gsrs_pkg, gsrs_cell_map, gsrs_acc_bank, gsrs_emit_seq.
//
// Usage:
//   An item is taken on a clock edge with start high and busy low.
//   Set (cmd 0) writes the cell's group; a group at or above group_count
//   returns one error word the cycle after it is taken. Add (cmd 1) reads
//   the cell's group from the map RAM, then read-modify-writes the group's
//   48-bit saturating accumulator; sets and adds are taken one per cycle
//   while busy is low, back-to-back accumulates to one group are forwarded.
//   End of row (cmd 2) raises busy, waits for adds still in the
//   accumulator pipeline, then reads one group per cycle from the
//   accumulator RAM: group_count words on rsp_*, one per cycle, the last
//   flagged by rsp_last, appearing in the cycle that busy drops. All
//   accumulators are cleared at once by their valid bits. busy stays high
//   through the drain and the group reads.
//   Result words are strobed by rsp_valid for one cycle; the receiver must
//   take them. The csr channel writes group_count (clamped to 1..MAX_GROUPS)
//   and is always ready; write it only while idle.
//   Reset zeroes the accumulators and sets group_count to MAX_GROUPS;
//   the cell map keeps no reset and must be set before a cell is added.
module grouped_sparse_row_sum_top #(
   parameter int MAX_CELLS  = 65536,
   parameter int MAX_GROUPS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [gsrs_pkg::CMD_W-1:0]          req_cmd,
   input  logic [gsrs_pkg::CELL_W-1:0]         req_cell_index,
   input  logic [gsrs_pkg::GIDX_W-1:0]         req_group_index,
   input  logic signed [gsrs_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   output logic [gsrs_pkg::GIDX_W-1:0]         rsp_group_slot,
   output logic signed [gsrs_pkg::ACC_W-1:0]   rsp_sum,
   output logic                                rsp_last,
   output logic                                rsp_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gsrs_pkg::COUNT_W-1:0]        csr_data
);
   import gsrs_pkg::*;

   localparam int CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int GRP_AW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam logic [COUNT_W-1:0] GROUPS_MAX = COUNT_W'(MAX_GROUPS);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               s1_vld_ff;
   logic signed [VALUE_W-1:0] s1_value_ff;
   logic               err_vld_ff;
   logic [GIDX_W-1:0]  err_slot_ff;

   logic               accept;
   logic               cell_ok;
   logic               grp_ok;
   logic               map_wr;
   logic [CELL_AW-1:0] cell_addr;
   logic [GRP_AW-1:0]  map_grp;
   logic               add_vld;
   logic signed [ACC_W-1:0] bank_sum;
   logic               bank_pending;
   gsrs_emit_ctrl_type emit;
   logic [GRP_AW-1:0]  emit_addr;
   logic [GRP_AW-1:0]  emit_slot;

   assign accept    = start & ~busy;
   assign cell_ok   = CELL_CMP_W'(req_cell_index) < CELL_CMP_W'(MAX_CELLS);
   assign grp_ok    = COUNT_W'(req_group_index) < count_ff;
   assign cell_addr = CELL_AW'(req_cell_index);
   assign map_wr    = accept & (req_cmd == CMD_SET) & grp_ok & cell_ok;
   // drop adds whose group fell out of use after the set
   assign add_vld   = s1_vld_ff & (COUNT_W'(map_grp) < count_ff);

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         if (csr_data == '0) begin
            count_in = COUNT_W'(1);
         end else if (csr_data > GROUPS_MAX) begin
            count_in = GROUPS_MAX;
         end else begin
            count_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= GROUPS_MAX;
         s1_vld_ff  <= 1'b0;
         err_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         s1_vld_ff  <= accept & (req_cmd == CMD_ADD) & cell_ok;
         err_vld_ff <= accept & (req_cmd == CMD_SET) & ~grp_ok;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff <= req_value;
      err_slot_ff <= req_group_index;
   end

   gsrs_cell_map #(
      .DEPTH   (MAX_CELLS),
      .CELL_AW (CELL_AW),
      .GRP_AW  (GRP_AW)
   ) u_cell_map (
      .clock   (clock),
      .wr_en   (map_wr),
      .wr_addr (cell_addr),
      .wr_grp  (GRP_AW'(req_group_index)),
      .rd_en   (accept & (req_cmd == CMD_ADD) & cell_ok),
      .rd_addr (cell_addr),
      .rd_grp  (map_grp)
   );

   gsrs_acc_bank #(
      .MAX_GROUPS (MAX_GROUPS),
      .GRP_AW     (GRP_AW)
   ) u_acc_bank (
      .clock     (clock),
      .reset     (reset),
      .add_vld   (add_vld),
      .add_grp   (map_grp),
      .add_value (s1_value_ff),
      .emit_rd   (emit.rd_en),
      .emit_addr (emit_addr),
      .clear_all (emit.clear),
      .rd_sum    (bank_sum),
      .pending   (bank_pending)
   );

   gsrs_emit_seq #(
      .GRP_AW (GRP_AW)
   ) u_emit_seq (
      .clock       (clock),
      .reset       (reset),
      .start_emit  (accept & (req_cmd == CMD_EOR)),
      .pipe_busy   (s1_vld_ff | bank_pending),
      .group_count (count_ff),
      .ctrl        (emit),
      .rd_addr     (emit_addr),
      .slot        (emit_slot)
   );

   assign busy           = emit.busy;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = err_vld_ff | emit.vld;
   assign rsp_error      = err_vld_ff;
   assign rsp_last       = emit.vld & emit.last;
   assign rsp_group_slot = err_vld_ff ? err_slot_ff : GIDX_W'(emit_slot);
   assign rsp_sum        = err_vld_ff ? '0 : bank_sum;

   // error words and sum words never share a cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(err_vld_ff && emit.vld))
      else $error("error word and sum word in the same cycle");

   // the final sum word comes out with the block already idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last sum word while still busy");

   // an accumulate never competes with the walk for the read port
   a_port_free: assert property (@(posedge clock) disable iff (reset)
      !(add_vld && emit.rd_en))
      else $error("accumulate and walk read in the same cycle");

   // an error word follows a taken item
   a_err_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> $past(start && !busy))
      else $error("error word without a taken item");

endmodule

@@ sim/grouped_sparse_row_sum_top_tb.sv @@
// Testbench for grouped_sparse_row_sum_top: a directed table and random rows,
// each result word checked against an in-bench predictor or a word given in the table.
// Depends on gsrs_pkg and the grouped_sparse_row_sum_top RTL.
module grouped_sparse_row_sum_top_tb;
   import gsrs_pkg::*;

   localparam int GROUP_SLOTS   = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 15;
   localparam int MAX_REPORTS   = 40;
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [CELL_W-1:0]         cell_idx;
      logic [GIDX_W-1:0]         grp;
      logic signed [VALUE_W-1:0] value;
   } row_item_type;

   typedef struct packed {
      logic [GIDX_W-1:0]       slot;
      logic signed [ACC_W-1:0] sum;
      logic                    last;
      logic                    error;
   } sum_word_type;

   typedef enum logic {
      ROW_ITEM,
      ROW_COUNT
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      row_item_type       item;
      logic [COUNT_W-1:0] count;
      logic               typed;
      sum_word_type       word;
   } plan_row_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [CMD_W-1:0]            req_cmd;
   logic [CELL_W-1:0]           req_cell_index;
   logic [GIDX_W-1:0]           req_group_index;
   logic signed [VALUE_W-1:0]   req_value;
   logic                        rsp_valid;
   logic [GIDX_W-1:0]           rsp_group_slot;
   logic signed [ACC_W-1:0]     rsp_sum;
   logic                        rsp_last;
   logic                        rsp_error;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [COUNT_W-1:0]          csr_data;

   // predictor state
   logic [GIDX_W-1:0]       model_cell_group [0:65535];
   logic signed [ACC_W-1:0] model_group_acc [0:GROUP_SLOTS-1];
   int unsigned             model_group_count;
   logic [CELL_W-1:0]       known_cells [$];

   sum_word_type sum_words_due [$];
   plan_row_type plan_rows [$];
   sum_word_type no_word = '0;
   sum_word_type want;

   int cycle_count   = 0;
   int fail_count    = 0;
   int items_sent    = 0;
   int words_checked = 0;
   int count_writes  = 0;

   grouped_sparse_row_sum_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_cell_index  (req_cell_index),
      .req_group_index (req_group_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_group_slot  (rsp_group_slot),
      .rsp_sum         (rsp_sum),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, exp_val);
   endtask

   // Work out the words one accepted item causes and advance the predictor state.
   task automatic predict_row_sums(input row_item_type it, input bit emit);
      longint       acc_next;
      int unsigned  g;
      sum_word_type w;
      case (it.cmd)
         CMD_SET: begin
            if (it.grp >= model_group_count) begin
               w = '{slot: it.grp, sum: '0, last: 1'b0, error: 1'b1};
               if (emit) sum_words_due.push_back(w);
            end else begin
               model_cell_group[it.cell_idx] = it.grp;
               known_cells.push_back(it.cell_idx);
            end
         end
         CMD_ADD: begin
            g = model_cell_group[it.cell_idx];
            // drop adds whose group fell out of use after the set
            if (g < model_group_count) begin
               acc_next = longint'(model_group_acc[g]) + longint'($signed(it.value));
               if (acc_next > longint'(ACC_MAX)) acc_next = longint'(ACC_MAX);
               if (acc_next < longint'(ACC_MIN)) acc_next = longint'(ACC_MIN);
               model_group_acc[g] = acc_next[ACC_W-1:0];
            end
         end
         CMD_EOR: begin
            for (int k = 0; k < int'(model_group_count); k++) begin
               w = '{slot: k[GIDX_W-1:0], sum: model_group_acc[k],
                     last: (k == int'(model_group_count) - 1), error: 1'b0};
               if (emit) sum_words_due.push_back(w);
            end
            for (int k = 0; k < GROUP_SLOTS; k++) model_group_acc[k] = '0;
         end
         default: ;
      endcase
   endtask

   // Present one word and hold it until the block takes it.
   task automatic drive_word(input row_item_type it, input bit typed,
                             input sum_word_type typed_word);
      start           <= 1'b1;
      req_cmd         <= it.cmd;
      req_cell_index  <= it.cell_idx;
      req_group_index <= it.grp;
      req_value       <= it.value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_row_sums(it, !typed);
      if (typed) sum_words_due.push_back(typed_word);
      items_sent++;
   endtask

   task automatic hold_off(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Idle cycles come one at a time with a fixed chance each; none when calm.
   function automatic int pick_gap(input bit calm);
      int n;
      n = 0;
      if (calm) return 0;
      while ($urandom_range(99) < 35) n++;
      return n;
   endfunction

   // Drain every due word, let the pipeline settle, then write the count.
   task automatic write_group_count(input logic [COUNT_W-1:0] v);
      int unsigned c;
      start <= 1'b0;
      while (sum_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      c = v;
      if (c < 1) c = 1;
      if (c > GROUP_SLOTS) c = GROUP_SLOTS;
      model_group_count = c;
      count_writes++;
   endtask

   task automatic plan_item(input logic [CMD_W-1:0] cmd, input logic [CELL_W-1:0] cell_idx,
                            input logic [GIDX_W-1:0] grp, input logic [VALUE_W-1:0] value);
      plan_row_type row;
      row = '{kind: ROW_ITEM, item: '{cmd, cell_idx, grp, value}, count: '0, typed: 1'b0,
              word: '0};
      plan_rows.push_back(row);
   endtask

   task automatic plan_typed(input logic [CMD_W-1:0] cmd, input logic [CELL_W-1:0] cell_idx,
                             input logic [GIDX_W-1:0] grp, input logic [VALUE_W-1:0] value,
                             input sum_word_type w);
      plan_row_type row;
      row = '{kind: ROW_ITEM, item: '{cmd, cell_idx, grp, value}, count: '0, typed: 1'b1,
              word: w};
      plan_rows.push_back(row);
   endtask

   task automatic plan_count(input logic [COUNT_W-1:0] v);
      plan_row_type row;
      row = '{kind: ROW_COUNT, item: '0, count: v, typed: 1'b0, word: '0};
      plan_rows.push_back(row);
   endtask

   function automatic row_item_type random_item();
      row_item_type it;
      int           r;
      r           = int'($urandom_range(99));
      it.cell_idx = CELL_W'($urandom);
      it.grp      = GIDX_W'($urandom);
      it.value    = $urandom;
      if (r < 10) begin
         it.cmd = CMD_EOR;
      end else if (r < 35) begin
         it.cmd = CMD_SET;
         if ($urandom_range(99) < 80)
            it.grp = GIDX_W'($urandom_range(model_group_count - 1, 0));
      end else if (r < 92) begin
         // add only to cells whose group has been set
         it.cmd      = CMD_ADD;
         it.cell_idx = known_cells[$urandom_range(known_cells.size() - 1, 0)];
         if ($urandom_range(1) == 1) it.value = 32'($urandom_range(4000)) - 32'd2000;
      end else begin
         it.cmd = CMD_NOP;
      end
      return it;
   endfunction

   // Check every strobed word against the oldest one due.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  sum_words_due.size());
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_valid === 1'b1) begin
         if (sum_words_due.size() == 0) begin
            report_mismatch("word with nothing due, slot", rsp_group_slot, '0);
         end else begin
            want = sum_words_due.pop_front();
            words_checked++;
            if (rsp_group_slot !== want.slot) report_mismatch("group_slot", rsp_group_slot, want.slot);
            if (rsp_sum !== want.sum) report_mismatch("sum", rsp_sum, want.sum);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            if (rsp_error !== want.error) report_mismatch("error", rsp_error, want.error);
         end
      end
   end

   initial begin
      row_item_type       it;
      logic [COUNT_W-1:0] phase_count;
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_SET;
      req_cell_index  = '0;
      req_group_index = '0;
      req_value       = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      model_group_count = GROUP_SLOTS;
      for (int k = 0; k < GROUP_SLOTS; k++) model_group_acc[k] = '0;

      // directed table
      plan_count(7'd0);                                  // clamps to one group
      plan_typed(CMD_EOR, 16'h0000, 6'd0, 32'h0, '{6'd0, 48'sd0, 1'b1, 1'b0});
      plan_typed(CMD_SET, 16'h0000, 6'd1, 32'h0, '{6'd1, 48'sd0, 1'b0, 1'b1});
      plan_typed(CMD_SET, 16'hFFFF, 6'd63, 32'h0, '{6'd63, 48'sd0, 1'b0, 1'b1});
      plan_item(CMD_SET, 16'h0000, 6'd0, 32'h0);
      plan_item(CMD_ADD, 16'h0000, 6'd0, 32'h7FFF_FFFF);
      plan_item(CMD_ADD, 16'h0000, 6'd0, 32'h8000_0000);
      plan_item(CMD_EOR, 16'h0000, 6'd0, 32'h0);
      plan_count(7'd127);                                // clamps to all groups
      plan_item(CMD_SET, 16'hFFFF, 6'd63, 32'h0);
      plan_item(CMD_SET, 16'h5555, 6'h2A, 32'h0);
      plan_item(CMD_SET, 16'hAAAA, 6'h15, 32'h0);
      plan_item(CMD_ADD, 16'hFFFF, 6'd0, 32'hFFFF_FFFF);
      plan_item(CMD_ADD, 16'h5555, 6'h3F, 32'h0000_0001);
      plan_item(CMD_ADD, 16'hAAAA, 6'd0, 32'h1234_5678);
      plan_item(CMD_ADD, 16'hAAAA, 6'd0, 32'hEDCB_A988);
      plan_item(CMD_NOP, 16'hFFFF, 6'h3F, 32'hFFFF_FFFF);
      plan_item(CMD_EOR, 16'hFFFF, 6'h3F, 32'hFFFF_FFFF);
      plan_item(CMD_SET, 16'h0007, 6'd40, 32'h0);
      plan_count(7'd8);                                  // group 40 goes stale
      plan_item(CMD_ADD, 16'h0007, 6'd0, 32'd100);
      plan_item(CMD_ADD, 16'h0000, 6'd0, 32'd5);
      plan_typed(CMD_SET, 16'h0007, 6'd8, 32'h0, '{6'd8, 48'sd0, 1'b0, 1'b1});
      plan_item(CMD_EOR, 16'h0000, 6'd0, 32'h0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      foreach (plan_rows[i]) begin
         if (plan_rows[i].kind == ROW_COUNT) begin
            write_group_count(plan_rows[i].count);
         end else begin
            drive_word(plan_rows[i].item, plan_rows[i].typed, plan_rows[i].word);
            hold_off(pick_gap(1'b0));
         end
      end

      // random rows under several group counts
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: phase_count = 7'd64;
            1: phase_count = 7'd1;
            2: phase_count = 7'($urandom_range(63, 2));
            3: phase_count = 7'd127;
            default: phase_count = 7'($urandom_range(127, 0));
         endcase
         write_group_count(phase_count);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == PHASE_ITEMS / 2) begin
               // hold until every due word is out
               start <= 1'b0;
               @(posedge clock);
               while (sum_words_due.size() != 0) @(posedge clock);
            end
            it = random_item();
            drive_word(it, 1'b0, no_word);
            // phase two runs back to back
            hold_off(pick_gap(phase == 2));
         end
         drive_word('{CMD_EOR, 16'h0000, 6'd0, 32'h0}, 1'b0, no_word);
      end

      start <= 1'b0;
      while (sum_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d items, %0d result words checked, %0d group count writes",
               items_sent, words_checked, count_writes);
      $display("run included count clamping, stale groups, rejected sets and idle commands");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
